// ----- sv/pip_pkg.sv -----
// Shared types for the point-in-polygon crossing test.
// No dependencies; used by the top level and the parity stage.
package pip_pkg;

  // Per-edge control: edge straddles the query height, and its y span is negative
  typedef struct packed {
    logic en;
    logic flip;
  } edge_ctl_t;

  // Control that travels down the pipeline with each vertex transaction
  typedef struct packed {
    logic      valid;
    logic      last;
    edge_ctl_t e1;
    edge_ctl_t e2;
  } stage_ctl_t;

endpackage

// ----- sv/point_in_polygon_test.sv -----
// Point-in-polygon even-odd crossing test; depends on pip_pkg and the pip_* stages.
// A result passes the stage one, product and result registers before out_valid rises.
// Throughput: one vertex per cycle; the three pipeline stages advance together, so
// in_ready follows the result register (low only while a result waits unaccepted).
// Reset clears the polygon tracking, pipeline valid bits, parity and out_valid.
module point_in_polygon_test #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic                         last_vertex,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         inside_res
);

  localparam int W = COORD_BITS;

  logic adv;
  logic in_accept;

  // Polygon state
  logic                in_polygon;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic signed [W-1:0] prev_x;
  logic signed [W-1:0] prev_y;
  logic signed [W-1:0] held_query_x;
  logic signed [W-1:0] held_query_y;

  // Edge operands, combinational
  logic signed [W:0] e1_dxq, e1_span, e1_run, e1_rise;
  logic signed [W:0] e2_dxq, e2_span, e2_run, e2_rise;
  logic              e1_straddle, e1_neg, e2_straddle, e2_neg;

  // Stage one registers, plus the stage two control
  pip_pkg::stage_ctl_t s1_ctl;
  pip_pkg::stage_ctl_t s2_ctl;
  logic signed [W:0]   s1_e1_dxq, s1_e1_span, s1_e1_run, s1_e1_rise;
  logic signed [W:0]   s1_e2_dxq, s1_e2_span, s1_e2_run, s1_e2_rise;

  // Products
  logic signed [2*W+1:0] e1_lhs, e1_rhs, e2_lhs, e2_rhs;

  // Stall all stages only while a result waits
  assign adv       = ~out_valid | out_ready;
  assign in_ready  = adv;
  assign in_accept = in_valid & in_ready;

  // Edge from the new vertex to the previous one
  pip_edge_prep #(.W(W)) u_prep_e1 (
    .ax(vertex_x), .ay(vertex_y), .bx(prev_x), .by(prev_y),
    .qx(held_query_x), .qy(held_query_y),
    .dxq(e1_dxq), .span(e1_span), .run(e1_run), .rise(e1_rise),
    .straddle(e1_straddle), .span_neg(e1_neg)
  );

  // Closing edge from the first vertex to the new one
  pip_edge_prep #(.W(W)) u_prep_e2 (
    .ax(first_x), .ay(first_y), .bx(vertex_x), .by(vertex_y),
    .qx(held_query_x), .qy(held_query_y),
    .dxq(e2_dxq), .span(e2_span), .run(e2_run), .rise(e2_rise),
    .straddle(e2_straddle), .span_neg(e2_neg)
  );

  // Track polygon membership
  always_ff @(posedge clk) begin
    if (rst) begin
      in_polygon <= 1'b0;
    end else if (in_accept) begin
      in_polygon <= ~last_vertex;
    end
  end

  // Capture first vertex and query, and advance previous vertex
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!in_polygon) begin
        first_x      <= vertex_x;
        first_y      <= vertex_y;
        held_query_x <= query_x;
        held_query_y <= query_y;
      end
      prev_x <= vertex_x;
      prev_y <= vertex_y;
    end
  end

  // Stage one and stage two control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
      s2_ctl <= '0;
    end else if (adv) begin
      s1_ctl.valid   <= in_accept;
      s1_ctl.last    <= last_vertex;
      s1_ctl.e1.en   <= in_polygon & e1_straddle;
      s1_ctl.e1.flip <= e1_neg;
      s1_ctl.e2.en   <= in_polygon & last_vertex & e2_straddle;
      s1_ctl.e2.flip <= e2_neg;
      s2_ctl         <= s1_ctl;
    end
  end

  // Stage one operands
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_e1_dxq  <= e1_dxq;
      s1_e1_span <= e1_span;
      s1_e1_run  <= e1_run;
      s1_e1_rise <= e1_rise;
      s1_e2_dxq  <= e2_dxq;
      s1_e2_span <= e2_span;
      s1_e2_run  <= e2_run;
      s1_e2_rise <= e2_rise;
    end
  end

  // (qx - ax) * span against (bx - ax) * (qy - ay)
  pip_edge_mult #(.W(W)) u_mult_e1 (
    .clk(clk), .en(adv),
    .lhs_a(s1_e1_dxq), .lhs_b(s1_e1_span), .rhs_a(s1_e1_run), .rhs_b(s1_e1_rise),
    .lhs_prod(e1_lhs), .rhs_prod(e1_rhs)
  );

  pip_edge_mult #(.W(W)) u_mult_e2 (
    .clk(clk), .en(adv),
    .lhs_a(s1_e2_dxq), .lhs_b(s1_e2_span), .rhs_a(s1_e2_run), .rhs_b(s1_e2_rise),
    .lhs_prod(e2_lhs), .rhs_prod(e2_rhs)
  );

  pip_parity #(.W(W)) u_parity (
    .clk(clk), .rst(rst), .adv(adv), .ctl(s2_ctl),
    .e1_lhs(e1_lhs), .e1_rhs(e1_rhs), .e2_lhs(e2_lhs), .e2_rhs(e2_rhs),
    .out_valid(out_valid), .inside_res(inside_res)
  );

  // The closing edge only counts on the last vertex
  a_close_on_last: assert property (@(posedge clk) disable iff (rst)
    s1_ctl.e2.en |-> s1_ctl.last)
    else $error("closing edge enabled on a non-last vertex");

  // A last vertex ends the polygon
  a_last_ends_polygon: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_vertex) |=> !in_polygon)
    else $error("polygon still open after last vertex");

  // A first vertex forms no edge
  a_first_no_edge: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !in_polygon) |=> (!s1_ctl.e1.en && !s1_ctl.e2.en))
    else $error("edge enabled on first vertex");

  // Vertices that are not last produce no result
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (adv && !(s2_ctl.valid && s2_ctl.last)) |=> !out_valid)
    else $error("result without a last vertex");

endmodule

// ----- sv/pip_edge_prep.sv -----
// Edge operand preparation: straddle check and coordinate differences for one edge.
// Pure combinational; no package dependency.
module pip_edge_prep #(
  parameter int W = 32
) (
  input  logic signed [W-1:0] ax,
  input  logic signed [W-1:0] ay,
  input  logic signed [W-1:0] bx,
  input  logic signed [W-1:0] by,
  input  logic signed [W-1:0] qx,
  input  logic signed [W-1:0] qy,
  output logic signed [W:0]   dxq,
  output logic signed [W:0]   span,
  output logic signed [W:0]   run,
  output logic signed [W:0]   rise,
  output logic                straddle,
  output logic                span_neg
);

  // Widen by one bit so differences never overflow
  assign dxq  = {qx[W-1], qx} - {ax[W-1], ax};
  assign span = {by[W-1], by} - {ay[W-1], ay};
  assign run  = {bx[W-1], bx} - {ax[W-1], ax};
  assign rise = {qy[W-1], qy} - {ay[W-1], ay};

  // Exactly one endpoint at or above the query height
  assign straddle = (ay >= qy) != (by >= qy);
  assign span_neg = span[W];

endmodule

// ----- sv/pip_edge_mult.sv -----
// Cross-multiplication stage for one edge: two registered signed products.
// No package dependency.
module pip_edge_mult #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W:0]     lhs_a,
  input  logic signed [W:0]     lhs_b,
  input  logic signed [W:0]     rhs_a,
  input  logic signed [W:0]     rhs_b,
  output logic signed [2*W+1:0] lhs_prod,
  output logic signed [2*W+1:0] rhs_prod
);

  // Advance products with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      lhs_prod <= lhs_a * lhs_b;
      rhs_prod <= rhs_a * rhs_b;
    end
  end

endmodule

// ----- sv/pip_parity.sv -----
// Compare stage: decides crossings, accumulates parity, holds the result register.
// Depends on pip_pkg for the pipeline control struct.
module pip_parity #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  pip_pkg::stage_ctl_t   ctl,
  input  logic signed [2*W+1:0] e1_lhs,
  input  logic signed [2*W+1:0] e1_rhs,
  input  logic signed [2*W+1:0] e2_lhs,
  input  logic signed [2*W+1:0] e2_rhs,
  output logic                  out_valid,
  output logic                  inside_res
);

  logic parity;
  logic cross1;
  logic cross2;
  logic parity_next;

  // A negative span flips the inequality instead of negating operands
  always_comb begin
    cross1 = ctl.e1.en & (ctl.e1.flip ? (e1_lhs >= e1_rhs) : (e1_lhs <= e1_rhs));
    cross2 = ctl.e2.en & (ctl.e2.flip ? (e2_lhs >= e2_rhs) : (e2_lhs <= e2_rhs));
    parity_next = parity ^ cross1 ^ cross2;
  end

  // Accumulate parity, clear it on the last vertex, and load the result
  always_ff @(posedge clk) begin
    if (rst) begin
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (ctl.valid) begin
        parity <= ctl.last ? 1'b0 : parity_next;
      end
      out_valid <= ctl.valid & ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inside_res <= parity_next;
    end
  end

endmodule

// ----- dv/point_in_polygon_test_test.sv -----
// Testbench for point_in_polygon_test: streams polygons with valid/ready stalls on both sides.
// Depends on the point_in_polygon_test RTL only; a scoreboard class predicts each inside flag.
module point_in_polygon_test_test;

  localparam int COORD_BITS = 32;
  localparam int ITEMS = 1900;
  localparam int QUIET_TAIL = 200;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 10;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Even-odd crossing predictor and queue of expected inside flags
  class inside_scoreboard;
    coord_t anchor_x, anchor_y, trail_x, trail_y, probe_x, probe_y;
    bit     crossing_odd;
    bit     open_poly;
    bit     inside_due[$];
    int     errors;
    int     checked;
    int     polygons;

    function new();
      anchor_x = '0; anchor_y = '0; trail_x = '0; trail_y = '0;
      probe_x = '0; probe_y = '0;
      crossing_odd = 0; open_poly = 0;
      errors = 0; checked = 0; polygons = 0;
    endfunction

    // True when edge a-b straddles the probe height with the probe at or left of it
    function bit edge_flips(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      wide_t span, rise, lhs, rhs;
      wide_t wax, way, wbx, wby, wqx, wqy;
      if ((ay >= probe_y) == (by >= probe_y)) return 0;
      wax = ax; way = ay; wbx = bx; wby = by; wqx = probe_x; wqy = probe_y;
      span = wby - way;
      rise = wqy - way;
      // fold the sign of the y span into both sides
      if (span < 0) begin
        span = -span;
        rise = -rise;
      end
      lhs = (wqx - wax) * span;
      rhs = (wbx - wax) * rise;
      return lhs <= rhs;
    endfunction

    // Advance the predictor by one accepted vertex transaction
    function void note_vertex(coord_t vx, coord_t vy, coord_t qx, coord_t qy, bit closing);
      if (!open_poly) begin
        probe_x = qx; probe_y = qy;
        anchor_x = vx; anchor_y = vy;
        trail_x = vx; trail_y = vy;
        crossing_odd = 0;
        open_poly = 1;
      end else begin
        if (edge_flips(vx, vy, trail_x, trail_y)) crossing_odd ^= 1'b1;
        trail_x = vx; trail_y = vy;
        if (closing && edge_flips(anchor_x, anchor_y, vx, vy)) crossing_odd ^= 1'b1;
      end
      if (closing) begin
        inside_due.insert(inside_due.size(), crossing_odd);
        polygons++;
        anchor_x = '0; anchor_y = '0; trail_x = '0; trail_y = '0;
        probe_x = '0; probe_y = '0;
        crossing_odd = 0; open_poly = 0;
      end
    endfunction

    // Compare one accepted result transaction with the oldest expectation
    function void check_inside(bit got);
      bit want;
      if (inside_due.size() == 0) begin
        $error("inside_res arrived with nothing expected: actual %0b", got);
        errors++;
        return;
      end
      want = inside_due.pop_front();
      checked++;
      if (got !== want) begin
        $error("inside_res mismatch: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return inside_due.size();
    endfunction
  endclass

  logic   clk = 0;
  logic   rst = 1;
  logic   in_valid = 0;
  logic   in_ready;
  coord_t vertex_x = '0;
  coord_t vertex_y = '0;
  coord_t query_x = '0;
  coord_t query_y = '0;
  logic   last_vertex = 0;
  logic   out_valid;
  logic   out_ready = 0;
  logic   inside_res;

  inside_scoreboard sb = new();

  bit     idle_on = 1;
  bit     long_hold_req = 0;
  int     vertices_sent = 0;
  coord_t poly_x[$];
  coord_t poly_y[$];

  point_in_polygon_test #(.COORD_BITS(COORD_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .vertex_x(vertex_x),
    .vertex_y(vertex_y),
    .query_x(query_x),
    .query_y(query_y),
    .last_vertex(last_vertex),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .inside_res(inside_res)
  );

  always #5 clk = ~clk;

  // Hard stop for a hung run
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // Sample result transactions
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_inside(inside_res);
  end

  // Drive out_ready: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        out_ready = 0;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready = 1;
      end else if (!rst && idle_on && $urandom_range(0, 7) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        out_ready = !rst;
      end
    end
  end

  function automatic coord_t rand_coord(int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic add_vertex(input coord_t x, input coord_t y);
    poly_x.insert(poly_x.size(), x);
    poly_y.insert(poly_y.size(), y);
  endtask

  // Offer one vertex transaction, optionally after an idle burst, and hold until taken
  task automatic drive_vertex(input coord_t x, input coord_t y, input coord_t qx,
                              input coord_t qy, input bit closing);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 17);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    vertex_x = x;
    vertex_y = y;
    query_x = qx;
    query_y = qy;
    last_vertex = closing;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_vertex(x, y, qx, qy, closing);
    vertices_sent++;
  endtask

  // Send the polygon held in poly_x/poly_y; query fields on later vertices are noise
  task automatic send_polygon(input coord_t qx, input coord_t qy);
    int n;
    n = poly_x.size();
    for (int i = 0; i < n; i++) begin
      if (i == 0) drive_vertex(poly_x[i], poly_y[i], qx, qy, n == 1);
      else drive_vertex(poly_x[i], poly_y[i], coord_t'($urandom), coord_t'($urandom),
                        i == n - 1);
    end
    poly_x.delete();
    poly_y.delete();
  endtask

  initial begin
    int     pick, nverts, span, idx;
    bit     hold_done;
    coord_t qx, qy;
    hold_done = 0;

    repeat (12) @(negedge clk);
    rst = 0;

    // Single-vertex polygons at the coordinate extremes
    add_vertex(CMAX, CMAX);
    send_polygon(CMIN, CMIN);
    add_vertex(CMIN, CMIN);
    send_polygon(CMAX, CMAX);

    // Axis-aligned square: query in the middle, then on the right and left edges
    add_vertex(0, 0); add_vertex(10, 0); add_vertex(10, 10); add_vertex(0, 10);
    send_polygon(5, 5);
    add_vertex(0, 0); add_vertex(10, 0); add_vertex(10, 10); add_vertex(0, 10);
    send_polygon(10, 5);
    add_vertex(0, 0); add_vertex(10, 0); add_vertex(10, 10); add_vertex(0, 10);
    send_polygon(0, 5);

    // Horizontal base with the query at its height
    add_vertex(-8, 2); add_vertex(8, 2); add_vertex(0, 9);
    send_polygon(0, 2);

    // Full-span triangle: query near center, then in a far corner
    add_vertex(CMIN, CMIN); add_vertex(CMAX, CMIN); add_vertex(0, CMAX);
    send_polygon(0, 0);
    add_vertex(CMIN, CMIN); add_vertex(CMAX, CMIN); add_vertex(0, CMAX);
    send_polygon(CMAX, CMAX);

    // Random polygons: half small grids for ties and flat edges, the rest wider ones
    while (vertices_sent < ITEMS) begin
      if (vertices_sent >= ITEMS - QUIET_TAIL) idle_on = 0;
      if (!hold_done && vertices_sent >= 600) begin
        long_hold_req = 1;
        hold_done = 1;
      end
      pick = $urandom_range(0, 9);
      nverts = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      span = (pick < 5) ? 20 : (pick < 8) ? (1 << 20) : 0;
      for (int k = 0; k < nverts; k++) begin
        if (span == 0) add_vertex(coord_t'($urandom), coord_t'($urandom));
        else add_vertex(rand_coord(span), rand_coord(span));
      end
      case ($urandom_range(0, 3))
        0: begin
          // query takes one vertex's column and a possibly different vertex's row
          idx = $urandom_range(0, nverts - 1);
          qx = poly_x[idx];
          qy = poly_y[$urandom_range(0, nverts - 1)];
        end
        default: begin
          if (span == 0) begin
            qx = coord_t'($urandom);
            qy = coord_t'($urandom);
          end else begin
            qx = rand_coord(span + 2);
            qy = rand_coord(span + 2);
          end
        end
      endcase
      send_polygon(qx, qy);
    end

    @(negedge clk);
    in_valid = 0;
    last_vertex = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d vertices in %0d polygons; %0d inside flags compared.",
             vertices_sent, sb.polygons, sb.checked);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
